### rtl/utf8_decode_glyph_address_macros.svh
// Assertion macros for the UTF-8 glyph address decoder checker.
// Uses the clock and reset names of the module that expands them.
`ifndef UTF8_DECODE_GLYPH_ADDRESS_MACROS_SVH
`define UTF8_DECODE_GLYPH_ADDRESS_MACROS_SVH

// same-cycle implication, off during reset
`define U8G_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("u8glyph check failed");

// next-cycle implication, off during reset
`define U8G_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("u8glyph check failed");

// next-cycle implication, also checked across reset
`define U8G_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("u8glyph check failed");

`endif

### rtl/u8glyph_pkg.sv
// Shared widths, codes, reset values, types and helpers of the UTF-8 glyph
// address decoder. No dependencies.
package u8glyph_pkg;

   localparam int GLYPH_BYTES = 32;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int CODE_W   = 21;
   localparam int LEN_W    = 3;
   localparam int CNT_W    = 16;
   localparam int ADDR_W   = 32;
   localparam int LEFT_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FONT_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_FIRST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LAST  = 2'd2;

   localparam logic [ADDR_W-1:0] RESET_FONT_BASE   = 32'h0025_C000;
   localparam logic [CODE_W-1:0] RESET_RANGE_FIRST = 21'h004E00;
   localparam logic [CODE_W-1:0] RESET_RANGE_LAST  = 21'h009FFF;

   localparam logic [ADDR_W-1:0] ADDR_NONE = {ADDR_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

   localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] font_base;
      logic [CODE_W-1:0] range_first;
      logic [CODE_W-1:0] range_last;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] code_point;
      logic [LEN_W-1:0]  char_length;
      logic [CNT_W-1:0]  char_index;
      logic [CNT_W-1:0]  start_offset;
      logic [CNT_W-1:0]  total_chars;
   } item_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

### rtl/u8glyph_ifs.sv
// Valid/ready channel interfaces: string bytes in, decoded items out.
// Depends on u8glyph_pkg.
interface u8glyph_req_if;
   import u8glyph_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
   modport monitor (input valid, input data_byte, input ready);
endinterface

interface u8glyph_rsp_if;
   import u8glyph_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [CODE_W-1:0] code_point;
   logic [LEN_W-1:0]  char_length;
   logic [CNT_W-1:0]  char_index;
   logic [CNT_W-1:0]  start_offset;
   logic [ADDR_W-1:0] glyph_addr;
   logic              addr_valid;
   logic [CNT_W-1:0]  total_chars;

   modport source (output valid, output kind, output code_point, output char_length,
                   output char_index, output start_offset, output glyph_addr,
                   output addr_valid, output total_chars, input ready);
   modport sink (input valid, input kind, input code_point, input char_length,
                 input char_index, input start_offset, input glyph_addr,
                 input addr_valid, input total_chars, output ready);
   modport monitor (input valid, input kind, input code_point, input char_length,
                    input char_index, input start_offset, input glyph_addr,
                    input addr_valid, input total_chars, input ready);
endinterface

### rtl/u8glyph_decoder.sv
// Byte-level UTF-8 decoder: string state, counters and the first result
// register. Depends on u8glyph_pkg.
module u8glyph_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [u8glyph_pkg::BYTE_W-1:0] in_byte,
   output logic                         out_valid,
   input  logic                         out_ready,
   output u8glyph_pkg::item_type        out_item
);
   import u8glyph_pkg::*;

   logic [LEFT_W-1:0] bytes_left_ff, bytes_left_in;
   logic [CODE_W-1:0] code_accum_ff, code_accum_in;
   logic [LEN_W-1:0]  cur_length_ff, cur_length_in;
   logic [CNT_W-1:0]  byte_position_ff, byte_position_in;
   logic [CNT_W-1:0]  char_start_ff, char_start_in;
   logic [CNT_W-1:0]  chars_seen_ff, chars_seen_in;
   logic              error_seen_ff, error_seen_in;

   logic              valid_ff, valid_in;
   item_type          item_ff, item_in;

   logic              accept;
   logic              has_result;
   logic [CODE_W-1:0] accum_shift;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   assign accum_shift = {code_accum_ff[CODE_W-7:0], in_byte[5:0]};

   always_comb begin
      bytes_left_in    = bytes_left_ff;
      code_accum_in    = code_accum_ff;
      cur_length_in    = cur_length_ff;
      byte_position_in = byte_position_ff;
      char_start_in    = char_start_ff;
      chars_seen_in    = chars_seen_ff;
      error_seen_in    = error_seen_ff;
      has_result       = 1'b0;
      item_in.kind         = KIND_CHAR;
      item_in.code_point   = '0;
      item_in.char_length  = '0;
      item_in.char_index   = chars_seen_ff;
      item_in.start_offset = char_start_ff;
      item_in.total_chars  = '0;

      if (in_byte == '0) begin
         has_result = 1'b1;
         if (!error_seen_ff && bytes_left_ff != '0) begin
            item_in.kind = KIND_ERR;
         end else begin
            item_in.kind         = KIND_END;
            item_in.start_offset = byte_position_ff;
            item_in.total_chars  = error_seen_ff ? '0 : chars_seen_ff;
         end
         bytes_left_in    = '0;
         code_accum_in    = '0;
         cur_length_in    = '0;
         byte_position_in = '0;
         char_start_in    = '0;
         chars_seen_in    = '0;
         error_seen_in    = 1'b0;
      end else if (error_seen_ff) begin
         has_result = 1'b0;
      end else if (bytes_left_ff == '0) begin
         byte_position_in = sat_inc(byte_position_ff);
         if (!in_byte[7]) begin
            char_start_in        = byte_position_ff;
            has_result           = 1'b1;
            item_in.code_point   = CODE_W'(in_byte);
            item_in.char_length  = LEN_ONE;
            item_in.start_offset = byte_position_ff;
            chars_seen_in        = sat_inc(chars_seen_ff);
            code_accum_in        = '0;
            cur_length_in        = '0;
         end else if (in_byte[7:5] == 3'b110) begin
            code_accum_in = CODE_W'(in_byte[4:0]);
            bytes_left_in = 2'd1;
            cur_length_in = LEN_TWO;
            char_start_in = byte_position_ff;
         end else if (in_byte[7:4] == 4'b1110) begin
            code_accum_in = CODE_W'(in_byte[3:0]);
            bytes_left_in = 2'd2;
            cur_length_in = LEN_THREE;
            char_start_in = byte_position_ff;
         end else if (in_byte[7:3] == 5'b11110) begin
            code_accum_in = CODE_W'(in_byte[2:0]);
            bytes_left_in = 2'd3;
            cur_length_in = LEN_FOUR;
            char_start_in = byte_position_ff;
         end else begin
            has_result           = 1'b1;
            item_in.kind         = KIND_ERR;
            item_in.start_offset = byte_position_ff;
            error_seen_in        = 1'b1;
            code_accum_in        = '0;
            cur_length_in        = '0;
         end
      end else begin
         byte_position_in = sat_inc(byte_position_ff);
         if (in_byte[7:6] != 2'b10) begin
            has_result    = 1'b1;
            item_in.kind  = KIND_ERR;
            error_seen_in = 1'b1;
            bytes_left_in = '0;
            code_accum_in = '0;
            cur_length_in = '0;
         end else if (bytes_left_ff == 2'd1) begin
            has_result          = 1'b1;
            item_in.code_point  = accum_shift;
            item_in.char_length = cur_length_ff;
            chars_seen_in       = sat_inc(chars_seen_ff);
            bytes_left_in       = '0;
            code_accum_in       = '0;
            cur_length_in       = '0;
         end else begin
            code_accum_in = accum_shift;
            bytes_left_in = bytes_left_ff - 2'd1;
         end
      end
   end

   always_comb begin
      if (accept) begin
         valid_in = has_result;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff    <= '0;
         code_accum_ff    <= '0;
         cur_length_ff    <= '0;
         byte_position_ff <= '0;
         char_start_ff    <= '0;
         chars_seen_ff    <= '0;
         error_seen_ff    <= 1'b0;
         valid_ff         <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            bytes_left_ff    <= bytes_left_in;
            code_accum_ff    <= code_accum_in;
            cur_length_ff    <= cur_length_in;
            byte_position_ff <= byte_position_in;
            char_start_ff    <= char_start_in;
            chars_seen_ff    <= chars_seen_in;
            error_seen_ff    <= error_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         item_ff <= item_in;
      end
   end

endmodule

### rtl/u8glyph_addr_unit.sv
// Glyph address pipeline: range check and offset, then scale and add base
// into the output register. Depends on u8glyph_pkg.
module u8glyph_addr_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  u8glyph_pkg::cfg_type  cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  u8glyph_pkg::item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output u8glyph_pkg::item_type out_item,
   output logic [u8glyph_pkg::ADDR_W-1:0] out_addr,
   output logic                  out_addr_valid
);
   import u8glyph_pkg::*;

   logic              s2_valid_ff, s2_valid_in;
   item_type          s2_item_ff;
   logic              s2_hit_ff, s2_hit_in;
   logic [CODE_W-1:0] s2_delta_ff;

   logic              s3_valid_ff, s3_valid_in;
   item_type          s3_item_ff;
   logic [ADDR_W-1:0] s3_addr_ff, s3_addr_in;
   logic              s3_hit_ff;

   logic              s3_free;
   logic              s2_move;
   logic              s1_move;

   assign s3_free  = !s3_valid_ff || out_ready;
   assign s2_move  = s2_valid_ff && s3_free;
   assign in_ready = !s2_valid_ff || s3_free;
   assign s1_move  = in_valid && in_ready;

   assign s2_hit_in = (in_item.kind == KIND_CHAR) &&
                      (in_item.code_point >= cfg.range_first) &&
                      (in_item.code_point <= cfg.range_last);

   assign s3_addr_in = s2_hit_ff ?
      cfg.font_base + ADDR_W'(s2_delta_ff) * ADDR_W'(GLYPH_BYTES) : ADDR_NONE;

   always_comb begin
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (s3_free) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
      if (s2_move) begin
         s3_valid_in = 1'b1;
      end else if (out_ready) begin
         s3_valid_in = 1'b0;
      end else begin
         s3_valid_in = s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_item_ff  <= in_item;
         s2_hit_ff   <= s2_hit_in;
         s2_delta_ff <= in_item.code_point - cfg.range_first;
      end
      if (s2_move) begin
         s3_item_ff <= s2_item_ff;
         s3_addr_ff <= s3_addr_in;
         s3_hit_ff  <= s2_hit_ff;
      end
   end

   assign out_valid      = s3_valid_ff;
   assign out_item       = s3_item_ff;
   assign out_addr       = s3_addr_ff;
   assign out_addr_valid = s3_hit_ff;

endmodule

### rtl/utf8_decode_glyph_address.sv
// UTF-8 decoder with glyph addressing: one item per character, string end or error.
// Throughput: one byte per cycle through a three-register pipeline
// (decode, range check, address scale and add); rsp back-pressure stalls it.
// Reset (synchronous): clears string state and pipeline, loads CSR defaults.
// Depends on u8glyph_pkg, u8glyph_ifs, u8glyph_decoder, u8glyph_addr_unit.
module utf8_decode_glyph_address (
   input  logic                              clock,
   input  logic                              reset,
   u8glyph_req_if.sink                       req_chan,
   u8glyph_rsp_if.source                     rsp_chan,
   input  logic                              csr_write_en,
   input  logic [u8glyph_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [u8glyph_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import u8glyph_pkg::*;

   cfg_type  cfg_ff;
   logic     dec_valid;
   logic     dec_ready;
   item_type dec_item;
   item_type rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.font_base   <= RESET_FONT_BASE;
         cfg_ff.range_first <= RESET_RANGE_FIRST;
         cfg_ff.range_last  <= RESET_RANGE_LAST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FONT_BASE:   cfg_ff.font_base   <= csr_write_data[ADDR_W-1:0];
            CSR_RANGE_FIRST: cfg_ff.range_first <= csr_write_data[CODE_W-1:0];
            CSR_RANGE_LAST:  cfg_ff.range_last  <= csr_write_data[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   u8glyph_decoder decoder (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_byte   (req_chan.data_byte),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_item  (dec_item)
   );

   u8glyph_addr_unit addr_unit (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (dec_valid),
      .in_ready       (dec_ready),
      .in_item        (dec_item),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .out_item       (rsp_item),
      .out_addr       (rsp_chan.glyph_addr),
      .out_addr_valid (rsp_chan.addr_valid)
   );

   assign rsp_chan.kind         = rsp_item.kind;
   assign rsp_chan.code_point   = rsp_item.code_point;
   assign rsp_chan.char_length  = rsp_item.char_length;
   assign rsp_chan.char_index   = rsp_item.char_index;
   assign rsp_chan.start_offset = rsp_item.start_offset;
   assign rsp_chan.total_chars  = rsp_item.total_chars;

endmodule

### rtl/u8glyph_checker.sv
// Port-level checks on the UTF-8 glyph address decoder, bound to its top.
// Depends on u8glyph_pkg, u8glyph_ifs and the assertion macro header.
`include "utf8_decode_glyph_address_macros.svh"

module u8glyph_checker (
   input  logic            clock,
   input  logic            reset,
   u8glyph_req_if.sink     req_chan,
   u8glyph_rsp_if.source   rsp_chan
);
   import u8glyph_pkg::*;

   logic rsp_stall;
   logic req_idle;

   assign rsp_stall = rsp_chan.valid && !rsp_chan.ready;
   assign req_idle  = !(req_chan.valid && req_chan.ready);

   `U8G_ASSERT_NEXT_ALWAYS(rsp_empty_after_reset, reset, !rsp_chan.valid)
   `U8G_ASSERT_NEXT(rsp_held_on_stall, rsp_stall,
      rsp_chan.valid && $stable(rsp_chan.kind) && $stable(rsp_chan.glyph_addr))
   `U8G_ASSERT_NOW(addr_only_for_char, rsp_chan.valid && rsp_chan.addr_valid,
      rsp_chan.kind == KIND_CHAR && rsp_chan.char_length != '0)
   `U8G_ASSERT_NOW(end_total_matches, rsp_chan.valid && rsp_chan.kind == KIND_END &&
      rsp_chan.total_chars != '0, rsp_chan.total_chars == rsp_chan.char_index)
   `U8G_ASSERT_NEXT(no_result_without_byte, !rsp_chan.valid && req_idle &&
      $past(req_idle) && $past(req_idle, 2) && $past(!rsp_chan.valid) &&
      $past(!rsp_chan.valid, 2), !rsp_chan.valid)

endmodule

bind utf8_decode_glyph_address u8glyph_checker checker_inst (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
